@@ rtl/core/aqbc_pkg.sv @@
// aqbc_pkg: shared types, codes and helpers for the affine quad box check
// no dependencies

package aqbc_pkg;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOT_RECT = 2'd1;
	localparam logic [1:0] ST_AREA     = 2'd2;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RATIO  = 2'd2;
	localparam logic [1:0] REG_AREA   = 2'd3;

	// distance root: 59-bit sum of squares, padded to an even width
	localparam int DIST_SQ_W = 60;
	localparam int DIST_W    = DIST_SQ_W / 2;
	// spread root: 64-bit sum of squared deviations
	localparam int SPREAD_SQ_W = 64;
	localparam int SPREAD_W    = SPREAD_SQ_W / 2;

	localparam int FRONT_LAT  = 6;
	localparam int MID_LAT    = 4;
	localparam int LATENCY    = FRONT_LAT + DIST_W + MID_LAT + SPREAD_W + 1;
	localparam int BOX_DLY    = DIST_W + MID_LAT + SPREAD_W;

	typedef struct packed {
		logic               area_over;
		logic signed [31:0] left;
		logic signed [31:0] top;
		logic        [31:0] width;
		logic        [31:0] height;
	} box_t;

	function automatic logic signed [31:0] sat32(input logic signed [46:0] v);
		logic signed [46:0] hi;
		logic signed [46:0] lo;
		hi = 47'sh7FFF_FFFF;
		lo = -47'sh8000_0000;
		if (v > hi) begin
			sat32 = 32'sh7FFF_FFFF;
		end else if (v < lo) begin
			sat32 = 32'sh8000_0000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

endpackage

@@ rtl/core/aqbc_isqrt.sv @@
// aqbc_isqrt: pipelined floor square root, one result bit per stage
// depends on nothing; one item per cycle

module aqbc_isqrt #(
	parameter int IN_W = 60
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [IN_W-1:0]       in_value,
	output logic                  out_valid,
	output logic [IN_W/2-1:0]     out_root
);

	localparam int OUT_W = IN_W / 2;
	localparam int REM_W = OUT_W + 2;

	logic [REM_W-1:0] rem_s  [OUT_W+1];
	logic [OUT_W-1:0] root_s [OUT_W+1];
	logic [IN_W-1:0]  rest_s [OUT_W+1];
	logic             vld_s  [OUT_W+1];

	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rest_s[0] = in_value;
	assign vld_s[0]  = in_valid;

	for (genvar k = 0; k < OUT_W; k++) begin : g_stage
		logic [REM_W-1:0] rem_sh;
		logic [REM_W-1:0] trial;
		logic             ge;

		always_comb begin
			rem_sh = {rem_s[k][REM_W-3:0], rest_s[k][IN_W-1:IN_W-2]};
			trial  = {root_s[k], 2'b01};
			ge     = (rem_sh >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
			root_s[k+1] <= {root_s[k][OUT_W-2:0], ge};
			rest_s[k+1] <= {rest_s[k][IN_W-3:0], 2'b00};
		end
	end

	assign out_valid = vld_s[OUT_W];
	assign out_root  = root_s[OUT_W];

endmodule

@@ rtl/core/aqbc_front.sv @@
// aqbc_front: corner mapping, bounding box, area test and squared distances
// depends on aqbc_pkg; six register stages

module aqbc_front #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic signed [31:0]  coef_xx,
	input  logic signed [31:0]  coef_xy,
	input  logic signed [31:0]  offset_x,
	input  logic signed [31:0]  coef_yx,
	input  logic signed [31:0]  coef_yy,
	input  logic signed [31:0]  offset_y,
	input  logic [11:0]         tmpl_w,
	input  logic [11:0]         tmpl_h,
	input  logic [31:0]         area_limit,
	output logic                out_valid,
	output logic [58:0]         dist_sq [4],
	output aqbc_pkg::box_t      box
);

	localparam int CMP_W = 64 + 2 * FRAC_BITS;

	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	logic signed [44:0] mxw_s1, mxh_s1, myw_s1, myh_s1;
	logic signed [31:0] ox_s1, oy_s1;

	logic signed [31:0] px_s2 [4];
	logic signed [31:0] py_s2 [4];

	logic signed [31:0] px_s3 [4];
	logic signed [31:0] py_s3 [4];
	logic signed [33:0] sx_s3, sy_s3;
	logic signed [31:0] xmin_s3, ymin_s3;
	logic        [31:0] bw_s3, bh_s3;

	logic        [28:0] mx_s4 [4];
	logic        [28:0] my_s4 [4];
	logic        [63:0] prod_s4;
	logic signed [31:0] xmin_s4, ymin_s4;
	logic        [31:0] bw_s4, bh_s4;

	logic        [57:0] qx_s5 [4];
	logic        [57:0] qy_s5 [4];
	aqbc_pkg::box_t     box_s5;

	logic        [58:0] v_s6 [4];
	aqbc_pkg::box_t     box_s6;

	logic signed [31:0] xmin_c, xmax_c, ymin_c, ymax_c;
	logic signed [32:0] bw_c, bh_c;
	logic        [28:0] mx_c [4];
	logic        [28:0] my_c [4];
	logic signed [34:0] dx_c, dy_c;
	logic        [34:0] ax_c, ay_c;

	// min and max over the four corners
	always_comb begin
		xmin_c = px_s2[0];
		xmax_c = px_s2[0];
		ymin_c = py_s2[0];
		ymax_c = py_s2[0];
		for (int i = 1; i < 4; i++) begin
			if (px_s2[i] < xmin_c) xmin_c = px_s2[i];
			if (px_s2[i] > xmax_c) xmax_c = px_s2[i];
			if (py_s2[i] < ymin_c) ymin_c = py_s2[i];
			if (py_s2[i] > ymax_c) ymax_c = py_s2[i];
		end
		bw_c = {xmax_c[31], xmax_c} - {xmin_c[31], xmin_c};
		bh_c = {ymax_c[31], ymax_c} - {ymin_c[31], ymin_c};
	end

	// centroid distance components in units of 16 lsb
	always_comb begin
		dx_c = '0;
		dy_c = '0;
		ax_c = '0;
		ay_c = '0;
		for (int i = 0; i < 4; i++) begin
			dx_c = {px_s3[i][31], px_s3[i], 2'b00} - {sx_s3[33], sx_s3};
			dy_c = {py_s3[i][31], py_s3[i], 2'b00} - {sy_s3[33], sy_s3};
			ax_c = dx_c[34] ? 35'(-dx_c) : 35'(dx_c);
			ay_c = dy_c[34] ? 35'(-dy_c) : 35'(dy_c);
			mx_c[i] = ax_c[34:6];
			my_c[i] = ay_c[34:6];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		// s1: gain times template size
		mxw_s1 <= coef_xx * $signed({1'b0, tmpl_w});
		mxh_s1 <= coef_xy * $signed({1'b0, tmpl_h});
		myw_s1 <= coef_yx * $signed({1'b0, tmpl_w});
		myh_s1 <= coef_yy * $signed({1'b0, tmpl_h});
		ox_s1  <= offset_x;
		oy_s1  <= offset_y;

		// s2: saturated corners
		px_s2[0] <= ox_s1;
		px_s2[1] <= aqbc_pkg::sat32(47'(mxw_s1) + 47'(ox_s1));
		px_s2[2] <= aqbc_pkg::sat32(47'(mxh_s1) + 47'(ox_s1));
		px_s2[3] <= aqbc_pkg::sat32(47'(mxw_s1) + 47'(mxh_s1) + 47'(ox_s1));
		py_s2[0] <= oy_s1;
		py_s2[1] <= aqbc_pkg::sat32(47'(myw_s1) + 47'(oy_s1));
		py_s2[2] <= aqbc_pkg::sat32(47'(myh_s1) + 47'(oy_s1));
		py_s2[3] <= aqbc_pkg::sat32(47'(myw_s1) + 47'(myh_s1) + 47'(oy_s1));

		// s3: coordinate sums and box
		px_s3   <= px_s2;
		py_s3   <= py_s2;
		sx_s3   <= 34'(px_s2[0]) + 34'(px_s2[1]) + 34'(px_s2[2]) + 34'(px_s2[3]);
		sy_s3   <= 34'(py_s2[0]) + 34'(py_s2[1]) + 34'(py_s2[2]) + 34'(py_s2[3]);
		xmin_s3 <= xmin_c;
		ymin_s3 <= ymin_c;
		bw_s3   <= bw_c[31:0];
		bh_s3   <= bh_c[31:0];

		// s4: distance components, box area
		mx_s4   <= mx_c;
		my_s4   <= my_c;
		prod_s4 <= bw_s3 * bh_s3;
		xmin_s4 <= xmin_s3;
		ymin_s4 <= ymin_s3;
		bw_s4   <= bw_s3;
		bh_s4   <= bh_s3;

		// s5: squares, area limit
		for (int i = 0; i < 4; i++) begin
			qx_s5[i] <= mx_s4[i] * mx_s4[i];
			qy_s5[i] <= my_s4[i] * my_s4[i];
		end
		box_s5.area_over <= CMP_W'(prod_s4) > (CMP_W'(area_limit) << (2 * FRAC_BITS));
		box_s5.left      <= xmin_s4;
		box_s5.top       <= ymin_s4;
		box_s5.width     <= bw_s4;
		box_s5.height    <= bh_s4;

		// s6: squared distances
		for (int i = 0; i < 4; i++) begin
			v_s6[i] <= 59'(qx_s5[i]) + 59'(qy_s5[i]);
		end
		box_s6 <= box_s5;
	end

	assign out_valid = vld_s6;
	assign dist_sq   = v_s6;
	assign box       = box_s6;

endmodule

@@ rtl/core/affine_quad_box_check_unit.sv @@
// affine_quad_box_check_unit: top level, config registers and spread test
// depends on aqbc_pkg, aqbc_front, aqbc_isqrt

// Maps the four template corners through a Q16.16 affine transform and gives
// one result item per accepted item: a status (ok, not rectangle-like, area
// above limit) and the axis-aligned box, zero on reject. The block is a
// pipeline that takes a new item every cycle, so busy stays low. It is built from
// the two bit-per-stage square root pipelines (30 stages for the corner
// distances, 32 for the spread) plus eleven stages of mapping, box, statistics
// and output logic. Results cannot be held off: done is high for exactly one
// cycle per item. The user must write configuration over the register port only
// while no item is in flight; the block itself does not enforce this.

module affine_quad_box_check_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// item input
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] coef_xx,
	input  logic signed [31:0] coef_xy,
	input  logic signed [31:0] offset_x,
	input  logic signed [31:0] coef_yx,
	input  logic signed [31:0] coef_yy,
	input  logic signed [31:0] offset_y,
	// result
	output logic               done,
	output logic [1:0]         status,
	output logic signed [31:0] box_left,
	output logic signed [31:0] box_top,
	output logic [30:0]        box_width,
	output logic [30:0]        box_height,
	// register port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int DW = aqbc_pkg::DIST_W;
	localparam int SW = aqbc_pkg::SPREAD_W;

	// configuration registers
	logic [11:0] tmpl_w_q;
	logic [11:0] tmpl_h_q;
	logic [7:0]  ratio_q;
	logic [31:0] area_limit_q;

	logic        wr_en;
	logic [1:0]  reg_idx;

	assign pready  = 1'b1;
	assign busy    = 1'b0;          // the pipeline never stalls
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmpl_w_q     <= '0;
			tmpl_h_q     <= '0;
			ratio_q      <= 8'd25;
			area_limit_q <= 32'd100000;
		end else if (wr_en) begin
			case (reg_idx)
				aqbc_pkg::REG_WIDTH:  tmpl_w_q     <= pwdata[11:0];
				aqbc_pkg::REG_HEIGHT: tmpl_h_q     <= pwdata[11:0];
				aqbc_pkg::REG_RATIO:  ratio_q      <= pwdata[7:0];
				aqbc_pkg::REG_AREA:   area_limit_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			aqbc_pkg::REG_WIDTH:  prdata = {20'd0, tmpl_w_q};
			aqbc_pkg::REG_HEIGHT: prdata = {20'd0, tmpl_h_q};
			aqbc_pkg::REG_RATIO:  prdata = {24'd0, ratio_q};
			aqbc_pkg::REG_AREA:   prdata = area_limit_q;
			default:              prdata = '0;
		endcase
	end

	// front end: corners, box, area test, squared centroid distances
	logic           f_valid;
	logic [58:0]    f_dist_sq [4];
	aqbc_pkg::box_t f_box;

	aqbc_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (start & ~busy),
		.coef_xx    (coef_xx),
		.coef_xy    (coef_xy),
		.offset_x   (offset_x),
		.coef_yx    (coef_yx),
		.coef_yy    (coef_yy),
		.offset_y   (offset_y),
		.tmpl_w     (tmpl_w_q),
		.tmpl_h     (tmpl_h_q),
		.area_limit (area_limit_q),
		.out_valid  (f_valid),
		.dist_sq    (f_dist_sq),
		.box        (f_box)
	);

	// four distance roots in parallel lanes
	logic          d_valid [4];
	logic [DW-1:0] d_root  [4];

	for (genvar i = 0; i < 4; i++) begin : g_dist
		aqbc_isqrt #(
			.IN_W (aqbc_pkg::DIST_SQ_W)
		) u_sqrt (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (f_valid),
			.in_value  ({1'b0, f_dist_sq[i]}),
			.out_valid (d_valid[i]),
			.out_root  (d_root[i])
		);
	end

	// box info waits alongside both root pipelines
	aqbc_pkg::box_t box_dly_q [aqbc_pkg::BOX_DLY];

	always_ff @(posedge clk) begin
		box_dly_q[0] <= f_box;
		for (int k = 1; k < aqbc_pkg::BOX_DLY; k++) begin
			box_dly_q[k] <= box_dly_q[k-1];
		end
	end

	// spread statistics: sum of distances, deviations, squares, sum of squares
	logic          vld_s1, vld_s2, vld_s3, vld_s4;
	logic [DW-1:0] d_s1 [4];
	logic [31:0]   dsum_s1, dsum_s2, dsum_s3, dsum_s4;
	logic [31:0]   e_s2 [4];
	logic [63:0]   esq_s3 [4];
	logic [63:0]   esq_s4;
	logic [32:0]   e_c  [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			// 4*d - D as a 33-bit two's complement value, then magnitude
			e_c[i] = {1'b0, d_s1[i], 2'b00} - {1'b0, dsum_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= d_valid[0];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		d_s1    <= d_root;
		dsum_s1 <= 32'(d_root[0]) + 32'(d_root[1]) + 32'(d_root[2]) + 32'(d_root[3]);
		for (int i = 0; i < 4; i++) begin
			e_s2[i]   <= e_c[i][32] ? 32'(-e_c[i]) : e_c[i][31:0];
			esq_s3[i] <= e_s2[i] * e_s2[i];
		end
		dsum_s2 <= dsum_s1;
		dsum_s3 <= dsum_s2;
		esq_s4  <= esq_s3[0] + esq_s3[1] + esq_s3[2] + esq_s3[3];
		dsum_s4 <= dsum_s3;
	end

	// spread root, mean sum carried beside it
	logic          sp_valid;
	logic [SW-1:0] sp_root;
	logic [31:0]   dsum_dly_q [SW];

	aqbc_isqrt #(
		.IN_W (aqbc_pkg::SPREAD_SQ_W)
	) u_spread (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s4),
		.in_value  (esq_s4),
		.out_valid (sp_valid),
		.out_root  (sp_root)
	);

	always_ff @(posedge clk) begin
		dsum_dly_q[0] <= dsum_s4;
		for (int k = 1; k < SW; k++) begin
			dsum_dly_q[k] <= dsum_dly_q[k-1];
		end
	end

	// decision and result register
	logic           not_rect_c;
	aqbc_pkg::box_t box_c;

	assign box_c      = box_dly_q[aqbc_pkg::BOX_DLY-1];
	assign not_rect_c = (ratio_q * sp_root) > {7'd0, dsum_dly_q[SW-1], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= sp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (not_rect_c) begin
			status     <= aqbc_pkg::ST_NOT_RECT;
			box_left   <= '0;
			box_top    <= '0;
			box_width  <= '0;
			box_height <= '0;
		end else if (box_c.area_over) begin
			status     <= aqbc_pkg::ST_AREA;
			box_left   <= '0;
			box_top    <= '0;
			box_width  <= '0;
			box_height <= '0;
		end else begin
			status     <= aqbc_pkg::ST_OK;
			box_left   <= box_c.left;
			box_top    <= box_c.top;
			// saturate to the 31-bit output range
			box_width  <= box_c.width[31]  ? 31'h7FFF_FFFF : box_c.width[30:0];
			box_height <= box_c.height[31] ? 31'h7FFF_FFFF : box_c.height[30:0];
		end
	end

endmodule

@@ rtl/core/aqbc_checker.sv @@
// aqbc_checker: port-level assertions for affine_quad_box_check_unit
// depends on aqbc_pkg; bound to the top level at the end of this file

module aqbc_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               done,
	input  logic [1:0]         status,
	input  logic signed [31:0] box_left,
	input  logic signed [31:0] box_top,
	input  logic [30:0]        box_width,
	input  logic [30:0]        box_height
);

	// every result traces back to an item taken a fixed latency earlier
	a_done_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start & ~busy, aqbc_pkg::LATENCY))
		else $error("result without a matching item");

	// an item taken is answered after the fixed latency
	a_item_answered: assert property (@(posedge clk) disable iff (!arst_n)
		(start & ~busy) |-> ##(aqbc_pkg::LATENCY) done)
		else $error("item lost in pipeline");

	// rejects carry an empty box
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != aqbc_pkg::ST_OK) |->
		(box_left == 0 && box_top == 0 && box_width == 0 && box_height == 0))
		else $error("reject with nonzero box");

	// status code three is never produced
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == aqbc_pkg::ST_OK || status == aqbc_pkg::ST_NOT_RECT ||
		          status == aqbc_pkg::ST_AREA))
		else $error("bad status code");

endmodule

bind affine_quad_box_check_unit aqbc_checker u_aqbc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.box_left   (box_left),
	.box_top    (box_top),
	.box_width  (box_width),
	.box_height (box_height)
);
